/* sv/sm3e_pkg.sv */
// sm3e_pkg: shared types, constants and helper functions of the sm3 hash engine
`timescale 1ns / 1ps

package sm3e_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] regs_t;
  typedef word_t [15:0] window_t;

  // control for one compression round
  typedef struct packed {
    logic  high_half;
    word_t tj;
  } rnd_ctl_t;

  localparam word_t T_LOW   = 32'h79cc4519;
  localparam word_t T_HIGH  = 32'h7a879d8a;
  localparam word_t PAD_TOP = 32'h80000000;

  localparam regs_t SM3_IV = {
    32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
    32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
  };

  function automatic word_t rol32(word_t x, logic [4:0] n);
    return (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic word_t perm0(word_t x);
    return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
  endfunction

  function automatic word_t perm1(word_t x);
    return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
  endfunction

endpackage

/* sv/sm3_hash_engine_top.sv */
// sm3_hash_engine_top: sm3 digest engine with byte packing, padding and iterative rounds
`timescale 1ns / 1ps

// Message words arrive most significant byte first, valid_bytes of them
// counting (zero adds nothing, above four counts as four). A word that fits
// in the current 32-bit block slot is packed in its acceptance cycle, so
// aligned words go at one beat per cycle while no block is compressed; a
// word that straddles a slot has its remaining bytes packed in ST_TAKE.
// Each time 64 bytes are gathered the engine runs the compression: 64 rounds
// at one round per cycle through the single shared round unit, with the
// schedule expanded on the fly in a 16-word sliding window, then ST_FOLD
// folds into the chaining value and ST_TAKE resumes packing. A final beat
// adds the padding: ST_PADB writes the 0x80 byte, ST_PADF the zero or length
// words still to fill (up to sixteen), then one or two more compressions run,
// and the eight digest words come out, index 0 first, one per accepted beat
// with last_digest on index 7. No input beat is taken while a straddling word
// is packed, padding is added, a block is compressed or the digest is out;
// after the last digest beat the engine is back at the initial value ready for a new message.

module sm3_hash_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        first_word,
  input  logic        final_word,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        last_digest
);
  import sm3e_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_TAKE  = 7'b0000010,
    ST_ROUND = 7'b0000100,
    ST_FOLD  = 7'b0001000,
    ST_PADB  = 7'b0010000,
    ST_PADF  = 7'b0100000,
    ST_OUTP  = 7'b1000000
  } state_t;

  state_t     state;
  state_t     take_state;
  regs_t      chain;
  regs_t      regs;
  regs_t      regs_next;
  window_t    win;
  window_t    win_next;
  word_t      tj;
  logic [5:0] round;
  logic [63:0] bit_length;
  logic       pad;         // padding in progress
  logic       two_blk;     // padding spills into a second block
  logic [4:0] pfill;       // next block word to fill during padding
  logic [2:0] idx;
  word_t      held_data;   // bytes still to pack, next byte on top
  logic [2:0] held_rem;
  logic       fin;
  rnd_ctl_t   ctl;

  // packing datapath
  logic        accept;
  word_t       cur_data;
  logic [2:0]  cur_rem;
  logic        fin_src;
  logic [63:0] len_eff;
  logic [1:0]  lane;
  logic [2:0]  room;
  logic [2:0]  take;
  logic [2:0]  lane_end;
  word_t       keep_mask;
  word_t       ins_mask;
  word_t       old_word;
  word_t       take_word;
  word_t       pad_word;
  logic [63:0] len_new;
  word_t       data_left;
  logic [2:0]  rem_left;
  logic        wrap;

  // block buffer write port
  logic        buf_we;
  logic [3:0]  buf_idx;
  word_t       buf_wdata;

  assign accept     = data_valid && (state == ST_IDLE);
  assign data_stall = (state != ST_IDLE);

  always_comb begin
    if (state == ST_IDLE) begin
      cur_data = data_word;
      cur_rem  = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
      fin_src  = final_word;
    end else begin
      cur_data = held_data;
      cur_rem  = held_rem;
      fin_src  = fin;
    end
    // a start beat counts from an empty message
    len_eff   = (state == ST_IDLE && first_word) ? 64'd0 : bit_length;
    lane      = len_eff[4:3];
    room      = 3'd4 - {1'b0, lane};
    take      = (cur_rem < room) ? cur_rem : room;
    lane_end  = {1'b0, lane} + take;
    keep_mask = ~(32'hffffffff >> {lane, 3'b000});
    ins_mask  = (32'hffffffff >> {lane, 3'b000}) & ~(32'hffffffff >> {lane_end, 3'b000});
    old_word  = win[len_eff[8:5]];
    // lanes above the new bytes are cleared so stale words never leak
    take_word = (old_word & keep_mask) | ((cur_data >> {lane, 3'b000}) & ins_mask);
    pad_word  = (old_word & keep_mask) | (PAD_TOP >> {lane, 3'b000});
    len_new   = len_eff + {58'd0, take, 3'b000};
    data_left = cur_data << {take, 3'b000};
    rem_left  = cur_rem - take;
    wrap      = (len_new[8:3] == 6'd0);

    if (cur_rem == 3'd0) begin
      take_state = fin_src ? ST_PADB : ST_IDLE;
    end else if (wrap) begin
      take_state = ST_ROUND;
    end else if (rem_left != 3'd0) begin
      take_state = ST_TAKE;
    end else begin
      take_state = fin_src ? ST_PADB : ST_IDLE;
    end
  end

  always_comb begin
    buf_we    = 1'b0;
    buf_idx   = len_eff[8:5];
    buf_wdata = take_word;
    unique case (state)
      ST_IDLE: buf_we = accept && (cur_rem != 3'd0);
      ST_TAKE: buf_we = (cur_rem != 3'd0);
      ST_PADB: begin
        buf_we    = 1'b1;
        buf_wdata = pad_word;
      end
      ST_PADF: begin
        buf_we  = !pfill[4];
        buf_idx = pfill[3:0];
        if (!two_blk && pfill[3:0] == 4'd14) begin
          buf_wdata = bit_length[63:32];
        end else if (!two_blk && pfill[3:0] == 4'd15) begin
          buf_wdata = bit_length[31:0];
        end else begin
          buf_wdata = '0;
        end
      end
      ST_ROUND, ST_FOLD, ST_OUTP: buf_we = 1'b0;
      default: buf_we = 1'b0;
    endcase
  end

  assign ctl.high_half = (round[5:4] != 2'd0);
  assign ctl.tj        = tj;

  sm3e_round u_round (
    .regs      (regs),
    .win       (win),
    .ctl       (ctl),
    .regs_next (regs_next),
    .win_next  (win_next)
  );

  // block buffer doubles as the schedule window while compressing
  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      win <= win_next;
    end else if (buf_we) begin
      win[buf_idx] <= buf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      chain      <= SM3_IV;
      regs       <= '0;
      tj         <= T_LOW;
      round      <= '0;
      bit_length <= '0;
      pad        <= 1'b0;
      two_blk    <= 1'b0;
      pfill      <= '0;
      idx        <= '0;
      held_data  <= '0;
      held_rem   <= '0;
      fin        <= 1'b0;
    end else begin
      // prime the round unit while not compressing
      if (state != ST_ROUND && state != ST_FOLD) begin
        regs  <= chain;
        tj    <= T_LOW;
        round <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (first_word) begin
              chain <= SM3_IV;
            end
            bit_length <= len_new;
            held_data  <= data_left;
            held_rem   <= rem_left;
            fin        <= fin_src;
            state      <= take_state;
          end
        end
        ST_TAKE: begin
          bit_length <= len_new;
          held_data  <= data_left;
          held_rem   <= rem_left;
          state      <= take_state;
        end
        ST_PADB: begin
          pad     <= 1'b1;
          two_blk <= (bit_length[8:3] >= 6'd56);
          pfill   <= {1'b0, bit_length[8:5]} + 5'd1;
          state   <= ST_PADF;
        end
        ST_PADF: begin
          if (pfill[4] || pfill[3:0] == 4'd15) begin
            state <= ST_ROUND;
          end else begin
            pfill <= pfill + 5'd1;
          end
        end
        ST_ROUND: begin
          regs  <= regs_next;
          round <= round + 6'd1;
          tj    <= (round == 6'd15) ? rol32(T_HIGH, 5'd16) : rol32(tj, 5'd1);
          if (round == 6'd63) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          chain <= chain ^ regs;
          if (!pad) begin
            state <= ST_TAKE;
          end else if (two_blk) begin
            two_blk <= 1'b0;
            pfill   <= '0;
            state   <= ST_PADF;
          end else begin
            idx   <= '0;
            state <= ST_OUTP;
          end
        end
        ST_OUTP: begin
          if (!digest_stall) begin
            if (idx == 3'd7) begin
              chain      <= SM3_IV;
              bit_length <= '0;
              pad        <= 1'b0;
              fin        <= 1'b0;
              state      <= ST_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign digest_valid = (state == ST_OUTP);
  assign digest_word  = chain[idx];
  assign digest_index = idx;
  assign last_digest  = (idx == 3'd7);

  // no input beat is taken while the digest is out
  a_digest_blocks_input : assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> data_stall)
    else $error("input accepted during digest output");

  // a compression runs its rounds without a break
  a_rounds_contiguous : assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) && (round != 6'd63) |=> (state == ST_ROUND))
    else $error("compression rounds interrupted");

  // after the last digest beat the engine holds a fresh, empty message
  a_fresh_after_digest : assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_stall && last_digest |=>
      !data_stall && (bit_length == 64'd0) && (chain == SM3_IV))
    else $error("engine not reinitialised after digest");

endmodule

/* sv/sm3e_round.sv */
// sm3e_round: one sm3 compression round and one message expansion step
`timescale 1ns / 1ps

module sm3e_round (
  input  sm3e_pkg::regs_t    regs,
  input  sm3e_pkg::window_t  win,
  input  sm3e_pkg::rnd_ctl_t ctl,
  output sm3e_pkg::regs_t    regs_next,
  output sm3e_pkg::window_t  win_next
);
  import sm3e_pkg::*;

  word_t a12, ss1, ss2, ff, gg, tt1, tt2, wn;

  always_comb begin
    a12 = rol32(regs[0], 5'd12);
    ss1 = rol32(a12 + regs[4] + ctl.tj, 5'd7);
    ss2 = ss1 ^ a12;
    if (ctl.high_half) begin
      ff = (regs[0] & regs[1]) | (regs[0] & regs[2]) | (regs[1] & regs[2]);
      gg = (regs[4] & regs[5]) | (~regs[4] & regs[6]);
    end else begin
      ff = regs[0] ^ regs[1] ^ regs[2];
      gg = regs[4] ^ regs[5] ^ regs[6];
    end
    tt1 = ff + regs[3] + ss2 + (win[0] ^ win[4]);
    tt2 = gg + regs[7] + ss1 + win[0];

    regs_next[0] = tt1;
    regs_next[1] = regs[0];
    regs_next[2] = rol32(regs[1], 5'd9);
    regs_next[3] = regs[2];
    regs_next[4] = perm0(tt2);
    regs_next[5] = regs[4];
    regs_next[6] = rol32(regs[5], 5'd19);
    regs_next[7] = regs[6];

    // w[j+16] from the sliding window w[j..j+15]
    wn = perm1(win[0] ^ win[7] ^ rol32(win[13], 5'd15)) ^ rol32(win[3], 5'd7) ^ win[10];
    win_next = {wn, win[15:1]};
  end

endmodule

/* tb/sm3_hash_engine_top_tb.sv */
// sm3_hash_engine_top_tb: self-checking testbench for the sm3 hash engine top level
`timescale 1ns / 1ps

module sm3_hash_engine_top_tb;

  // sm3 initial value and round constants, kept apart from the design package
  localparam logic [31:0] IV_WORDS [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };
  localparam logic [31:0] TJ_EARLY = 32'h79cc4519;
  localparam logic [31:0] TJ_LATE  = 32'h7a879d8a;
  localparam logic [31:0] PAD_BYTE = 32'h80;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned RANDOM_BEATS = 240;
  localparam int unsigned STEADY_BEATS = 50;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [31:0] data_word = '0;
  logic [2:0]  valid_bytes = '0;
  logic        first_word = 1'b0;
  logic        final_word = 1'b0;
  logic        digest_valid;
  logic        digest_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        last_digest;

  // hash state mirrored by the testbench
  logic [31:0] chain_q [8];
  logic [31:0] blk_q [16];
  logic [63:0] msg_bits;

  digest_beat_t pending_digest [$];
  int unsigned  err_cnt = 0;
  int unsigned  beats_sent = 0;
  bit           idle_on = 1'b0;
  bit           stall_on = 1'b0;

  sm3_hash_engine_top dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_word    (data_word),
    .valid_bytes  (valid_bytes),
    .first_word   (first_word),
    .final_word   (final_word),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .digest_index (digest_index),
    .last_digest  (last_digest)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // hash model
  // ---------------------------------------------------------------------------

  // rotate left, amount taken mod 32
  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
    int unsigned s;
    s = n % 32;
    if (s == 0) begin
      return x;
    end
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] mix_p0(logic [31:0] x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic logic [31:0] mix_p1(logic [31:0] x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

  // fresh message: initial value, empty block, zero length
  function automatic void load_initial_value();
    for (int k = 0; k < 8; k++) begin
      chain_q[k] = IV_WORDS[k];
    end
    for (int k = 0; k < 16; k++) begin
      blk_q[k] = '0;
    end
    msg_bits = '0;
  endfunction

  // expand the block, run 64 rounds, fold into the chaining value
  function automatic void compress_model_block();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++) begin
      w[j] = blk_q[j];
    end
    for (int j = 16; j < 68; j++) begin
      w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
    end
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    e = chain_q[4]; f = chain_q[5]; g = chain_q[6]; h = chain_q[7];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? TJ_EARLY : TJ_LATE;
      a12 = rotl(a, 12);
      ss1 = rotl(a12 + e + rotl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rotl(b, 9); b = a; a = tt1;
      h = g; g = rotl(f, 19); f = e; e = mix_p0(tt2);
    end
    chain_q[0] ^= a; chain_q[1] ^= b; chain_q[2] ^= c; chain_q[3] ^= d;
    chain_q[4] ^= e; chain_q[5] ^= f; chain_q[6] ^= g; chain_q[7] ^= h;
    for (int j = 0; j < 16; j++) begin
      blk_q[j] = '0;
    end
  endfunction

  function automatic void pack_msg_byte(logic [7:0] b);
    int unsigned pos;
    pos = 32'(msg_bits[8:3]);
    blk_q[pos >> 2] |= {24'd0, b} << (24 - 8 * (pos % 4));
    msg_bits += 64'd8;
    if (msg_bits[8:3] == 6'd0) begin
      compress_model_block();
    end
  endfunction

  // one accepted data beat; a final beat pads and queues the eight digest words
  function automatic void hash_model_beat(logic [31:0] w, logic [2:0] nb, logic start,
                                          logic fin);
    int unsigned cnt;
    int unsigned pos;
    if (start) begin
      load_initial_value();
    end
    cnt = (nb > 3'd4) ? 4 : 32'(nb);
    for (int k = 0; k < cnt; k++) begin
      pack_msg_byte(w[31 - 8 * k -: 8]);
    end
    if (fin) begin
      pos = 32'(msg_bits[8:3]);
      blk_q[pos >> 2] |= PAD_BYTE << (24 - 8 * (pos % 4));
      // no room left for the length words: an extra block is needed
      if (pos + 1 > 56) begin
        compress_model_block();
      end
      blk_q[14] = msg_bits[63:32];
      blk_q[15] = msg_bits[31:0];
      compress_model_block();
      for (int k = 0; k < DIGEST_WORDS; k++) begin
        pending_digest.push_back('{chain_q[k], 3'(k), k == 7});
      end
      load_initial_value();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // beat driver, digest checker, output stall
  // ---------------------------------------------------------------------------

  // entered at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input logic [31:0] w, input logic [2:0] nb, input logic start,
                           input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    data_valid  <= 1'b1;
    data_word   <= w;
    valid_bytes <= nb;
    first_word  <= start;
    final_word  <= fin;
    do @(posedge clk); while (data_stall !== 1'b0);
    hash_model_beat(w, nb, start, fin);
    beats_sent++;
    @(negedge clk);
  endtask

  // hold the sender off until every queued digest word has come out
  task automatic wait_drained();
    data_valid <= 1'b0;
    while (pending_digest.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && digest_valid === 1'b1 && !digest_stall) begin
      if (pending_digest.size() == 0) begin
        $error("digest beat with nothing expected: word %h index %0d", digest_word,
               digest_index);
        err_cnt++;
      end else begin
        want = pending_digest.pop_front();
        if (digest_word !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, digest_word);
          err_cnt++;
        end
        if (digest_index !== want.idx) begin
          $error("digest_index: expected %0d, got %0d", want.idx, digest_index);
          err_cnt++;
        end
        if (last_digest !== want.last) begin
          $error("last_digest: expected %b, got %b", want.last, last_digest);
          err_cnt++;
        end
      end
    end
  end

  // receiver back-pressure in short random bursts
  always begin
    @(negedge clk);
    if (stall_on && $urandom_range(0, 3) == 0) begin
      digest_stall <= 1'b1;
      repeat ($urandom_range(1, 4)) @(negedge clk);
      digest_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every byte count 0..7, starting straight after reset with no start flag;
  // zero adds nothing, anything above four counts as four
  task automatic test_byte_counts();
    send_beat(32'hffffffff, 3'd0, 1'b0, 1'b0);
    send_beat(32'hffffffff, 3'd1, 1'b0, 1'b0);
    send_beat(32'h00000000, 3'd2, 1'b0, 1'b0);
    send_beat(32'ha5c3_5a3c, 3'd3, 1'b0, 1'b0);
    send_beat(32'hffffffff, 3'd4, 1'b0, 1'b0);
    send_beat(32'h0123_4567, 3'd5, 1'b0, 1'b0);
    send_beat(32'h89ab_cdef, 3'd6, 1'b0, 1'b0);
    send_beat(32'hfedc_ba98, 3'd7, 1'b0, 1'b1);
  endtask

  // start and final on the same beat: empty message, the classic "abc" and four zero bytes
  task automatic test_single_beat_messages();
    send_beat(32'hffffffff, 3'd0, 1'b1, 1'b1);
    send_beat(32'h61626300, 3'd3, 1'b1, 1'b1);
    send_beat(32'h00000000, 3'd4, 1'b1, 1'b1);
  endtask

  // a start flag mid-message throws away what was gathered so far
  task automatic test_restart_mid_message();
    send_beat(32'h1111_2222, 3'd4, 1'b1, 1'b0);
    send_beat(32'h3333_4444, 3'd4, 1'b0, 1'b0);
    send_beat(32'h5555_6666, 3'd2, 1'b1, 1'b1);
  endtask

  // 56 bytes: the pad byte leaves no room for the length, so two blocks follow
  task automatic test_pad_boundary();
    for (int i = 0; i < 14; i++) begin
      send_beat($urandom(), 3'd4, i == 0, i == 13);
    end
  endtask

  // length wrap needs 2^61 bytes and is out of reach in simulation

  // mostly well-formed messages; lengths bunch around one block so the
  // one-block and two-block padding paths both get plenty of hits
  task automatic send_random_message();
    int unsigned nwords;
    int unsigned sel;
    logic [2:0]  nb;
    logic        start;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      nwords = $urandom_range(1, 4);
    end else if (sel < 8) begin
      nwords = $urandom_range(13, 18);
    end else begin
      nwords = $urandom_range(19, 36);
    end
    for (int i = 0; i < nwords; i++) begin
      nb = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      // occasional missing start, rare stray restart inside the message
      start = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 31) == 0);
      send_beat($urandom(), nb, start, i == nwords - 1);
    end
  endtask

  task automatic test_random_messages(input int unsigned n_beats);
    int unsigned stop_at;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      send_random_message();
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
      end
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream(input int unsigned n_beats);
    int unsigned stop_at;
    stop_at = beats_sent + n_beats;
    idle_on  = 1'b0;
    stall_on = 1'b0;
    while (beats_sent < stop_at) begin
      send_random_message();
    end
  endtask

  initial begin
    load_initial_value();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_on  = 1'b1;
    stall_on = 1'b1;
    test_byte_counts();
    test_single_beat_messages();
    test_restart_mid_message();
    test_pad_boundary();
    // sender holds off until the engine has fully drained
    wait_drained();
    test_random_messages(RANDOM_BEATS);
    test_steady_stream(STEADY_BEATS);

    wait_drained();
    // room for any stray digest beat to show up
    repeat (300) @(negedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
